// ----- src/acuc_pkg.sv -----
// ============================================================================
// acuc_pkg: shared types and constants for the amoeba unit chaotic update
// Holds register indexes, reset values, the configuration bundle and the
// xorshift32 generator step used by the seed path.
// ============================================================================
`default_nettype none

package acuc_pkg;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_EPS_HIGH   = 2'd0;
    localparam logic [1:0] REG_EPS_LOW    = 2'd1;
    localparam logic [1:0] REG_CONN_LIMIT = 2'd2;
    localparam logic [1:0] REG_RNG_SEED   = 2'd3;

    // Operation codes
    localparam logic OP_STEP = 1'b0;
    localparam logic OP_SEED = 1'b1;

    // Reset values
    localparam logic [30:0] EPS_HIGH_RESET   = 31'd687194767;
    localparam logic [30:0] EPS_LOW_RESET    = 31'd515396076;
    localparam logic [11:0] CONN_LIMIT_RESET = 12'd20;
    localparam logic [31:0] RNG_SEED_RESET   = 32'd1;

    // Fixed points of the chaotic value
    localparam logic [31:0] HALF_POINT = 32'h4000_0000;
    localparam logic [31:0] ONE_POINT  = 32'h8000_0000;

    // Stored word: position over chaotic value
    localparam int UNIT_WORD_W = 34;

    typedef struct packed {
        logic [30:0] eps_high;
        logic [30:0] eps_low;
        logic [11:0] conn_limit;
    } t_cfg;

    // One xorshift32 step with shifts 13, 17, 5
    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] v;
        v = s;
        v = v ^ (v << 13);
        v = v ^ (v >> 17);
        v = v ^ (v << 5);
        return v;
    endfunction

    // A chaotic value of zero or one half is not usable
    function automatic logic chaos_invalid(input logic [31:0] z);
        return (z == 32'd0) || (z == HALF_POINT);
    endfunction

endpackage

`default_nettype wire

// ----- src/amoeba_unit_chaotic_update.sv -----
// ============================================================================
// amoeba_unit_chaotic_update: chaotic value and position update per unit
// Unit store in RAM, registered read stage, update stage with forwarding,
// output register, APB-style register port.
// ============================================================================
// Takes one item per cycle while the output is not stalled and no redraw is
// pending; an accepted item passes the update stage and its result is then
// loaded into the output register, which lets the next item enter while the
// result waits. Throughput is set by the single read-modify-write pass over
// the unit RAM; a back-to-back update of the same unit is served by a
// forwarding path. A seed of an invalid value whose generator draw is again
// invalid holds the update stage and draws again until a draw is usable.
// After reset, a clearing pass writes zero to every unit, one per cycle; the
// input ready stays low meanwhile while register writes are taken as usual. A
// unit index at or above UNIT_COUNT gives an all-zero result and changes
// nothing.
// ============================================================================
`default_nettype none

module amoeba_unit_chaotic_update #(
    parameter int UNIT_COUNT = 2048
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input channel
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire logic               i_operation,
    input  wire logic [10:0]        i_unit_index,
    input  wire logic               i_bounceback,
    input  wire logic [11:0]        i_connectivity_count,
    // Output channel
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      logic signed [1:0]  o_position,
    output      logic               o_fluctuation,
    output      logic [31:0]        o_chaos_value,
    // Register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output      logic [31:0]        prdata,
    output      logic               pready
);

    localparam int AW    = $clog2(UNIT_COUNT);
    localparam int CMP_W = 17;
    localparam int WW    = acuc_pkg::UNIT_WORD_W;

    // Registers
    logic [30:0] r_eps_high;
    logic [30:0] r_eps_low;
    logic [11:0] r_conn_limit;
    logic [31:0] r_rng_seed;
    logic [31:0] r_rng_state;
    logic [31:0] n_rng_state;
    acuc_pkg::t_cfg cfg;

    // Clearing pass
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    // Update stage
    logic              r_s1_valid;
    logic              r_s1_op;
    logic [10:0]       r_s1_index;
    logic              r_s1_bounce;
    logic [11:0]       r_s1_conn;
    logic              r_s1_in_range;
    logic              r_s1_fwd;
    logic [WW-1:0]     r_s1_fwd_data;
    logic              r_s1_redraw;
    logic [31:0]       r_s1_z;

    logic              cfg_wr;
    logic              in_accept;
    logic              out_free;
    logic              s1_go;
    logic              s1_done;
    logic [WW-1:0]     rd_data;
    logic [WW-1:0]     cur_word;
    logic [31:0]       cur_z;
    logic [31:0]       rng_next;
    logic [31:0]       draw_value;
    logic              need_draw;
    logic              redraw;
    logic [31:0]       new_z;
    logic signed [1:0] new_pos;
    logic              new_y;
    logic [WW-1:0]     new_word;
    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [WW-1:0]     ram_wr_data;

    // Register port decode
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            acuc_pkg::REG_EPS_HIGH:   prdata = {1'b0, r_eps_high};
            acuc_pkg::REG_EPS_LOW:    prdata = {1'b0, r_eps_low};
            acuc_pkg::REG_CONN_LIMIT: prdata = {20'd0, r_conn_limit};
            acuc_pkg::REG_RNG_SEED:   prdata = r_rng_seed;
            default:                  prdata = 32'd0;
        endcase
    end

    assign cfg.eps_high   = r_eps_high;
    assign cfg.eps_low    = r_eps_low;
    assign cfg.conn_limit = r_conn_limit;

    // Handshakes; an out-of-range beat never redraws
    assign out_free   = !o_out_valid || i_out_ready;
    assign s1_go      = r_s1_valid && out_free;
    assign s1_done    = s1_go && !(r_s1_in_range && redraw);
    assign o_in_ready = !r_clearing && (!r_s1_valid || s1_done);
    assign in_accept  = i_in_valid && o_in_ready;

    // Unit store
    acuc_ram #(
        .WIDTH (WW),
        .DEPTH (UNIT_COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (AW'(i_unit_index)),
        .o_rd_data (rd_data)
    );

    // Pick the current unit word: pending redraw, forwarded write, or RAM
    assign cur_word = r_s1_fwd ? r_s1_fwd_data : rd_data;
    assign cur_z    = r_s1_redraw ? r_s1_z : cur_word[31:0];

    // Generator draw
    assign rng_next   = acuc_pkg::xorshift32(r_rng_state);
    assign draw_value = {1'b0, rng_next[31:1]};

    acuc_update u_update (
        .i_operation          (r_s1_op),
        .i_chaos              (cur_z),
        .i_position           (cur_word[33:32]),
        .i_bounceback         (r_s1_bounce),
        .i_connectivity_count (r_s1_conn),
        .i_cfg                (cfg),
        .i_draw_value         (draw_value),
        .o_need_draw          (need_draw),
        .o_redraw             (redraw),
        .o_chaos              (new_z),
        .o_position           (new_pos),
        .o_fluctuation        (new_y)
    );

    assign new_word = {new_pos, new_z};

    // Write port: clearing pass or write-back
    assign ram_wr_en   = r_clearing || (s1_done && r_s1_in_range);
    assign ram_wr_addr = r_clearing ? r_clr_addr : AW'(r_s1_index);
    assign ram_wr_data = r_clearing ? '0 : new_word;

    // Next generator state: register write wins, else advance on a draw
    always_comb begin
        n_rng_state = r_rng_state;
        if (cfg_wr && (paddr[3:2] == acuc_pkg::REG_RNG_SEED)) begin
            n_rng_state = (pwdata == 32'd0) ? 32'd1 : pwdata;
        end else if (s1_go && r_s1_in_range && need_draw) begin
            n_rng_state = rng_next;
        end
    end

    // Configuration registers and generator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps_high   <= acuc_pkg::EPS_HIGH_RESET;
            r_eps_low    <= acuc_pkg::EPS_LOW_RESET;
            r_conn_limit <= acuc_pkg::CONN_LIMIT_RESET;
            r_rng_seed   <= acuc_pkg::RNG_SEED_RESET;
            r_rng_state  <= acuc_pkg::RNG_SEED_RESET;
        end else begin
            r_rng_state <= n_rng_state;
            if (cfg_wr) begin
                case (paddr[3:2])
                    acuc_pkg::REG_EPS_HIGH:   r_eps_high   <= pwdata[30:0];
                    acuc_pkg::REG_EPS_LOW:    r_eps_low    <= pwdata[30:0];
                    acuc_pkg::REG_CONN_LIMIT: r_conn_limit <= pwdata[11:0];
                    acuc_pkg::REG_RNG_SEED:   r_rng_seed   <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    // Clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(UNIT_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Update stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_redraw <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid  <= 1'b1;
            r_s1_redraw <= 1'b0;
        end else if (s1_done) begin
            r_s1_valid  <= 1'b0;
            r_s1_redraw <= 1'b0;
        end else if (s1_go && r_s1_in_range && redraw) begin
            r_s1_redraw <= 1'b1;
        end
    end

    // Update stage payload; capture forwarding of the write at this beat
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op       <= i_operation;
            r_s1_index    <= i_unit_index;
            r_s1_bounce   <= i_bounceback;
            r_s1_conn     <= i_connectivity_count;
            r_s1_in_range <= CMP_W'(i_unit_index) < CMP_W'(UNIT_COUNT);
            r_s1_fwd      <= s1_done && r_s1_in_range && (r_s1_index == i_unit_index);
            r_s1_fwd_data <= new_word;
        end else if (s1_go && redraw) begin
            r_s1_z <= draw_value;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (s1_done) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done) begin
            o_position    <= r_s1_in_range ? new_pos : 2'sd0;
            o_fluctuation <= r_s1_in_range && new_y;
            o_chaos_value <= r_s1_in_range ? new_z : 32'd0;
        end
    end

endmodule

`default_nettype wire

// ----- src/acuc_ram.sv -----
// ============================================================================
// acuc_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered, read-first on
// a same-address collision.
// ============================================================================
`default_nettype none

module acuc_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/acuc_update.sv -----
// ============================================================================
// acuc_update: per-unit update logic
// Tent map with feedback bit, growth bit against the connectivity-selected
// epsilon, saturating position move, and the seed selection with one draw.
// ============================================================================
`default_nettype none

module acuc_update (
    input  wire logic               i_operation,
    input  wire logic [31:0]        i_chaos,
    input  wire logic signed [1:0]  i_position,
    input  wire logic               i_bounceback,
    input  wire logic [11:0]        i_connectivity_count,
    input  wire acuc_pkg::t_cfg     i_cfg,
    input  wire logic [31:0]        i_draw_value,
    output      logic               o_need_draw,
    output      logic               o_redraw,
    output      logic [31:0]        o_chaos,
    output      logic signed [1:0]  o_position,
    output      logic               o_fluctuation
);

    logic        fb;
    logic [31:0] neg;
    logic [31:0] tent;
    logic [30:0] eps;
    logic [31:0] limit;
    logic        grow;

    // Tent map with wrap and feedback injection
    assign fb    = i_chaos[30] ^ i_chaos[20] ^ i_chaos[10];
    assign neg   = ~i_chaos + 32'd1;
    assign tent  = (i_chaos < acuc_pkg::HALF_POINT)
                 ? {i_chaos[30:0], fb}
                 : {neg[30:0], fb};

    // Growth bit against one minus epsilon
    assign eps   = (i_connectivity_count > i_cfg.conn_limit) ? i_cfg.eps_high
                                                             : i_cfg.eps_low;
    assign limit = acuc_pkg::ONE_POINT - {1'b0, eps};
    assign grow  = !i_bounceback && (tent < limit);

    // Seed draw control
    assign o_need_draw = (i_operation == acuc_pkg::OP_SEED)
                      && acuc_pkg::chaos_invalid(i_chaos);
    assign o_redraw    = o_need_draw && acuc_pkg::chaos_invalid(i_draw_value);

    // Select result
    always_comb begin
        o_chaos       = tent;
        o_position    = i_position;
        o_fluctuation = 1'b0;
        if (i_operation == acuc_pkg::OP_SEED) begin
            o_chaos    = o_need_draw ? i_draw_value : i_chaos;
            o_position = 2'sd0;
        end else begin
            o_fluctuation = grow;
            if (grow && (i_position != 2'sd1)) begin
                o_position = i_position + 2'sd1;
            end else if (!grow && (i_position != -2'sd1)) begin
                o_position = i_position - 2'sd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ============================================================================
// tb_top: testbench for the amoeba unit chaotic update
// Sends unit update beats over valid/ready with random gaps and stalls and
// programs the register port between phases. Every result beat is checked
// against a model of the unit store, the position levels and the generator.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNIT_COUNT  = 2048;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 200;

    typedef struct packed {
        logic signed [1:0] position;
        logic              fluctuation;
        logic [31:0]       chaos;
    } t_unit_result;

    // DUT connections
    logic              i_clk                = 1'b0;
    logic              i_rst_n              = 1'b0;
    logic              i_in_valid           = 1'b0;
    logic              o_in_ready;
    logic              i_operation          = acuc_pkg::OP_STEP;
    logic [10:0]       i_unit_index         = '0;
    logic              i_bounceback         = 1'b0;
    logic [11:0]       i_connectivity_count = '0;
    logic              o_out_valid;
    logic              i_out_ready          = 1'b0;
    logic signed [1:0] o_position;
    logic              o_fluctuation;
    logic [31:0]       o_chaos_value;
    logic              psel                 = 1'b0;
    logic              penable              = 1'b0;
    logic              pwrite               = 1'b0;
    logic [3:0]        paddr                = '0;
    logic [31:0]       pwdata               = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Model state and register copies
    logic [31:0]  chaos_mem [UNIT_COUNT];
    int           position_mem [UNIT_COUNT];
    logic [31:0]  rng_word       = acuc_pkg::RNG_SEED_RESET;
    logic [30:0]  cfg_eps_high   = acuc_pkg::EPS_HIGH_RESET;
    logic [30:0]  cfg_eps_low    = acuc_pkg::EPS_LOW_RESET;
    logic [11:0]  cfg_conn_limit = acuc_pkg::CONN_LIMIT_RESET;

    t_unit_result pending_updates [$];
    int           mismatch_count  = 0;
    int           send_idle_pct   = 0;
    int           recv_idle_pct   = 0;
    int unsigned  watchdog_cycles = 0;

    amoeba_unit_chaotic_update #(
        .UNIT_COUNT (UNIT_COUNT)
    ) i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_operation          (i_operation),
        .i_unit_index         (i_unit_index),
        .i_bounceback         (i_bounceback),
        .i_connectivity_count (i_connectivity_count),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_position           (o_position),
        .o_fluctuation        (o_fluctuation),
        .o_chaos_value        (o_chaos_value),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    // Generate the clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Advance the generator by one xorshift32 step
    function automatic logic [31:0] rng_advance(logic [31:0] s);
        logic [31:0] v;
        v = s ^ (s << 13);
        v = v ^ (v >> 17);
        return v ^ (v << 5);
    endfunction

    // Undo one generator step, to aim a draw at a chosen value
    function automatic logic [31:0] rng_rewind(logic [31:0] v);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = v;
        repeat (7) a = v ^ (a << 5);
        b = a;
        repeat (2) b = a ^ (b >> 17);
        c = b;
        repeat (3) c = b ^ (c << 13);
        return c;
    endfunction

    // Apply one unit update to the model and return the result beat
    function automatic t_unit_result compute_unit_update(logic op, logic [10:0] idx,
                                                         logic bb, logic [11:0] conn);
        t_unit_result r;
        logic [31:0]  z;
        logic         fb;
        logic [30:0]  eps;
        int           pos;
        int           draws;
        r = '0;
        if (int'(idx) >= UNIT_COUNT) return r;
        z   = chaos_mem[idx];
        pos = position_mem[idx];
        if (op == acuc_pkg::OP_SEED) begin
            // Redraw only while the value is unusable
            draws = 0;
            while ((z == 32'd0 || z == acuc_pkg::HALF_POINT) && draws < 8) begin
                rng_word = rng_advance(rng_word);
                z = rng_word >> 1;
                draws++;
            end
            pos = 0;
        end else begin
            // Tent map with feedback bit, then growth bit and position move
            fb = z[30] ^ z[20] ^ z[10];
            if (z < acuc_pkg::HALF_POINT) begin
                z = (z << 1) + 32'(fb);
            end else begin
                z = ((~z + 32'd1) << 1) + 32'(fb);
            end
            eps = (conn > cfg_conn_limit) ? cfg_eps_high : cfg_eps_low;
            r.fluctuation = !bb && (64'(z) < (64'h8000_0000 - 64'(eps)));
            if (r.fluctuation && pos < 1) begin
                pos++;
            end else if (!r.fluctuation && pos > -1) begin
                pos--;
            end
        end
        chaos_mem[idx]    = z;
        position_mem[idx] = pos;
        r.position = 2'(pos);
        r.chaos    = z;
        return r;
    endfunction

    // Check result beats in order, then record the prediction of an accepted beat
    always @(posedge i_clk) begin : check_results
        t_unit_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_updates.size() == 0) begin
                    $error("result beat with no pending update: pos %0d fl %0b chaos %h",
                           o_position, o_fluctuation, o_chaos_value);
                    mismatch_count++;
                end else begin
                    want = pending_updates.pop_front();
                    if (o_position !== want.position) begin
                        $error("position: expected %0d, got %0d", want.position, o_position);
                        mismatch_count++;
                    end
                    if (o_fluctuation !== want.fluctuation) begin
                        $error("fluctuation: expected %0b, got %0b",
                               want.fluctuation, o_fluctuation);
                        mismatch_count++;
                    end
                    if (o_chaos_value !== want.chaos) begin
                        $error("chaos_value: expected %h, got %h", want.chaos, o_chaos_value);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                pending_updates.push_back(compute_unit_update(i_operation, i_unit_index,
                                                              i_bounceback,
                                                              i_connectivity_count));
            end
        end
    end

    // Stop a hung run
    initial begin
        while (watchdog_cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            watchdog_cycles++;
        end
        $error("timeout after %0d cycles, %0d updates pending",
               watchdog_cycles, pending_updates.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Send one update beat, with a random gap first
    task automatic send_item(logic op, logic [10:0] idx, logic bb, logic [11:0] conn);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_operation          <= op;
        i_unit_index         <= idx;
        i_bounceback         <= bb;
        i_connectivity_count <= conn;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Drop valid and hold until every pending update has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register over the APB port and mirror it in the model
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            acuc_pkg::REG_EPS_HIGH:   cfg_eps_high   = data[30:0];
            acuc_pkg::REG_EPS_LOW:    cfg_eps_low    = data[30:0];
            acuc_pkg::REG_CONN_LIMIT: cfg_conn_limit = data[11:0];
            acuc_pkg::REG_RNG_SEED:   rng_word       = (data == 32'd0) ? 32'd1 : data;
            default: ;
        endcase
    endtask

    // Pick a register value: zero, all ones or random
    function automatic logic [31:0] pick_setting();
        case ($urandom_range(3))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic apply_random_settings();
        write_reg(acuc_pkg::REG_EPS_HIGH, pick_setting());
        write_reg(acuc_pkg::REG_EPS_LOW, pick_setting());
        write_reg(acuc_pkg::REG_CONN_LIMIT, pick_setting());
        write_reg(acuc_pkg::REG_RNG_SEED, ($urandom_range(9) == 0) ? 32'd0 : $urandom());
    endtask

    // A unit that was never seeded stays at zero and saturates both ways
    task automatic test_never_seeded_saturation();
        send_item(acuc_pkg::OP_STEP, 11'd0, 1'b0, 12'd0);
        send_item(acuc_pkg::OP_STEP, 11'd0, 1'b0, 12'd0);
        send_item(acuc_pkg::OP_STEP, 11'd0, 1'b1, 12'hFFF);
        send_item(acuc_pkg::OP_STEP, 11'd0, 1'b1, 12'hFFF);
        send_item(acuc_pkg::OP_STEP, 11'd0, 1'b1, 12'hFFF);
        send_item(acuc_pkg::OP_STEP, 11'd0, 1'b1, 12'd20);
        wait_for_results();
    endtask

    // Seed an invalid value, step around the limit, reseed a valid value
    task automatic test_seed_paths();
        send_item(acuc_pkg::OP_SEED, 11'd1, 1'b0, 12'd0);
        send_item(acuc_pkg::OP_STEP, 11'd1, 1'b0, 12'd20);
        send_item(acuc_pkg::OP_STEP, 11'd1, 1'b0, 12'd21);
        send_item(acuc_pkg::OP_SEED, 11'd1, 1'b1, 12'hFFF);
        send_item(acuc_pkg::OP_SEED, 11'h7FF, 1'b0, 12'd0);
        send_item(acuc_pkg::OP_STEP, 11'h7FF, 1'b1, 12'hFFF);
        wait_for_results();
    endtask

    // Aim the first draw at each value that forces a second draw
    task automatic test_repeated_draw();
        logic [31:0] bad_draws [3];
        bad_draws[0] = 32'h0000_0001;
        bad_draws[1] = 32'h8000_0000;
        bad_draws[2] = 32'h8000_0001;
        for (int k = 0; k < 3; k++) begin
            write_reg(acuc_pkg::REG_RNG_SEED, rng_rewind(bad_draws[k]));
            send_item(acuc_pkg::OP_SEED, 11'(2000 + k), 1'b0, 12'd0);
            wait_for_results();
        end
    endtask

    // A zero seed loads the generator with one
    task automatic test_zero_seed();
        write_reg(acuc_pkg::REG_RNG_SEED, 32'd0);
        send_item(acuc_pkg::OP_SEED, 11'd3, 1'b0, 12'd0);
        send_item(acuc_pkg::OP_STEP, 11'd3, 1'b0, 12'd0);
        wait_for_results();
    endtask

    // Extreme epsilons and limits
    task automatic test_epsilon_extremes();
        write_reg(acuc_pkg::REG_EPS_HIGH, 32'hFFFF_FFFF);
        write_reg(acuc_pkg::REG_EPS_LOW, 32'd0);
        write_reg(acuc_pkg::REG_CONN_LIMIT, 32'd0);
        send_item(acuc_pkg::OP_STEP, 11'd1, 1'b0, 12'd0);
        send_item(acuc_pkg::OP_STEP, 11'd1, 1'b0, 12'd1);
        send_item(acuc_pkg::OP_STEP, 11'd0, 1'b0, 12'hFFF);
        wait_for_results();
        write_reg(acuc_pkg::REG_CONN_LIMIT, 32'hFFFF_FFFF);
        write_reg(acuc_pkg::REG_EPS_LOW, 32'h7FFF_FFFF);
        send_item(acuc_pkg::OP_STEP, 11'd1, 1'b0, 12'hFFF);
        send_item(acuc_pkg::OP_STEP, 11'd0, 1'b0, 12'hFFF);
        wait_for_results();
    endtask

    // Random seed/step sequences, mostly on a few hot units
    task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
        logic [10:0] hot_units [8];
        logic        op;
        logic [10:0] idx;
        logic        bb;
        int          c;
        apply_random_settings();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        foreach (hot_units[k]) hot_units[k] = 11'($urandom());
        for (int n = 0; n < n_items; n++) begin
            // Let the pipeline run dry once mid-phase
            if (n == n_items / 2) wait_for_results();
            op  = ($urandom_range(99) < 15) ? acuc_pkg::OP_SEED : acuc_pkg::OP_STEP;
            idx = ($urandom_range(99) < 80) ? hot_units[$urandom_range(7)]
                                            : 11'($urandom_range(UNIT_COUNT - 1));
            bb  = ($urandom_range(99) < 25);
            if ($urandom_range(1) == 0) begin
                c = int'(cfg_conn_limit) + int'($urandom_range(2)) - 1;
                if (c < 0) c = 0;
                if (c > 4095) c = 4095;
            end else begin
                c = $urandom_range(4095);
            end
            send_item(op, idx, bb, 12'(c));
        end
        wait_for_results();
    endtask

    initial begin
        foreach (chaos_mem[u]) begin
            chaos_mem[u]    = '0;
            position_mem[u] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_never_seeded_saturation();
        test_seed_paths();
        test_repeated_draw();
        test_zero_seed();
        test_epsilon_extremes();
        test_random_traffic(PHASE_ITEMS, 11, 56);
        test_random_traffic(PHASE_ITEMS, 56, 11);
        test_random_traffic(PHASE_ITEMS, 0, 0);

        repeat (20) @(posedge i_clk);
        if (pending_updates.size() != 0) begin
            $error("%0d updates never came back", pending_updates.size());
        end
        if (mismatch_count == 0 && pending_updates.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
